[rtl/core/kvote_pkg.sv]
// Package of shared constants, payload types and register codes for the vote alarm.
`default_nettype none

package kvote_pkg;

	// Deepest window the history can hold, and the width of a timestamp.
	localparam int WINDOW_MAX = 32;
	localparam int TIME_BITS  = 32;

	// Widths that follow from the constants above or from the fixed register map.
	localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
	localparam int CFG_W      = 6;
	localparam int COOL_W     = 32;
	localparam int VOTES_W    = 6;
	localparam int CMP_W      = (TIME_BITS > COOL_W) ? TIME_BITS : COOL_W;
	localparam int GROUP_BITS = 8;
	localparam int GROUPS     = (WINDOW_MAX + GROUP_BITS - 1) / GROUP_BITS;
	localparam int DATA_W     = 32;
	localparam int IDX_W      = 2;

	// Register indexes on the configuration port.
	typedef enum logic [IDX_W-1:0] {
		CFG_WINDOW_SIZE    = 2'd0,
		CFG_REQUIRED_VOTES = 2'd1,
		CFG_COOLDOWN_TICKS = 2'd2
	} cfg_idx_t;

	// Reset values of the registers.
	localparam logic [CFG_W-1:0]  WINDOW_SIZE_RST    = 6'd8;
	localparam logic [CFG_W-1:0]  REQUIRED_VOTES_RST = 6'd6;
	localparam logic [COOL_W-1:0] COOLDOWN_RST       = 32'd3000;

	// One input transaction.
	typedef struct packed {
		logic                 fall_seen;
		logic [TIME_BITS-1:0] timestamp;
		logic                 player_ready;
	} in_t;

	// One result transaction.
	typedef struct packed {
		logic               alarm;
		logic [VOTES_W-1:0] votes;
		logic               window_full;
		logic               config_error;
	} out_t;

	// Window status handed from the window unit to the top level.
	typedef struct packed {
		logic [WIN_W-1:0] count;
		logic             full;
	} win_stat_t;

endpackage

`default_nettype wire

[rtl/core/k_of_n_vote_alarm.sv]
// Top level of the k-of-n sliding-window vote alarm.
//
// Input transactions carry one detector verdict, a tick timestamp and a
// player-ready flag on a valid/ready channel. Every input transaction gives
// exactly one result transaction with the alarm flag, the vote count over
// the window, the window-full flag and the configuration error flag.
// An accepted transaction is held in an input register; once the result
// register is free or being taken, the vote count and alarm decision are
// formed from it and written to the result register, which offers the
// result to the receiver until it is taken.
// One transaction is accepted in every cycle while results are taken; the
// rate is set by the single pass through the vote count and cooldown compare.
// When the receiver stalls, the result register holds and the input register
// fills; input ready then drops until the result is taken.
// Asynchronous reset clears the history, fill count, episode latch and last
// alarm time, empties both registers and returns the configuration registers
// to window size 8, six required votes and a cooldown of 3000 ticks.
// Configuration is written through a plain write port; the user must write it only while idle, not enforced here.
`default_nettype none

module k_of_n_vote_alarm (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire kvote_pkg::in_t            in_data,
	output logic                           out_valid,
	input  wire                            out_ready,
	output kvote_pkg::out_t                out_data,
	input  wire                            cfg_we,
	input  wire [kvote_pkg::IDX_W-1:0]     cfg_index,
	input  wire [kvote_pkg::DATA_W-1:0]    cfg_data
);

	logic [kvote_pkg::CFG_W-1:0]  window_size_q;
	logic [kvote_pkg::CFG_W-1:0]  required_votes_q;
	logic [kvote_pkg::COOL_W-1:0] cooldown_q;

	logic                 valid_s1;
	kvote_pkg::in_t       data_s1;
	logic                 out_valid_q;
	kvote_pkg::out_t      out_data_q;

	logic                        advance;
	logic                        fire;
	logic [kvote_pkg::WIN_W-1:0] win;
	logic                        cfg_err;
	logic                        wanted;
	logic                        alarm;
	kvote_pkg::win_stat_t        stat;
	kvote_pkg::out_t             result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q    <= kvote_pkg::WINDOW_SIZE_RST;
			required_votes_q <= kvote_pkg::REQUIRED_VOTES_RST;
			cooldown_q       <= kvote_pkg::COOLDOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kvote_pkg::CFG_WINDOW_SIZE: begin
					window_size_q <= cfg_data[kvote_pkg::CFG_W-1:0];
				end
				kvote_pkg::CFG_REQUIRED_VOTES: begin
					required_votes_q <= cfg_data[kvote_pkg::CFG_W-1:0];
				end
				kvote_pkg::CFG_COOLDOWN_TICKS: begin
					cooldown_q <= cfg_data[kvote_pkg::COOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake: the pipeline moves whenever the result register is free or taken.
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Clamp the window and check the configuration.
	always_comb begin
		if (window_size_q > kvote_pkg::WINDOW_MAX) begin
			win = kvote_pkg::WIN_W'(kvote_pkg::WINDOW_MAX);
		end else begin
			win = kvote_pkg::WIN_W'(window_size_q);
		end
		cfg_err = (required_votes_q == '0) || (required_votes_q > window_size_q) ||
			(window_size_q > kvote_pkg::WINDOW_MAX);
		wanted  = !cfg_err && stat.full && (stat.count >= required_votes_q);
	end

	kvote_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.verdict (data_s1.fall_seen),
		.win     (win),
		.stat    (stat)
	);

	kvote_alarm u_alarm (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.wanted       (wanted),
		.player_ready (data_s1.player_ready),
		.now          (data_s1.timestamp),
		.cooldown     (cooldown_q),
		.alarm        (alarm)
	);

	// Assemble the result transaction.
	always_comb begin
		result.alarm        = alarm;
		result.votes        = stat.count[kvote_pkg::VOTES_W-1:0];
		result.window_full  = stat.full;
		result.config_error = cfg_err;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An alarm needs a valid configuration and a full window.
	a_alarm_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.alarm |->
			!out_data_q.config_error && out_data_q.window_full)
		else $error("alarm raised with invalid configuration or partial window");

	// A committed alarm carries at least the required votes.
	a_alarm_votes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && alarm |-> stat.count >= required_votes_q)
		else $error("alarm raised below the vote threshold");

	// A held input transaction moves on whenever input ready is shown.
	a_ready_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_ready |-> fire)
		else $error("input register overwritten before its transaction was committed");

	// A committed transaction always appears in the result register.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("committed transaction lost its result");

endmodule

`default_nettype wire

[rtl/core/kvote_window.sv]
// Verdict history shift register, fill counter and windowed vote count.
`default_nettype none

module kvote_window (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          fire,
	input  wire                          verdict,
	input  wire [kvote_pkg::WIN_W-1:0]   win,
	output kvote_pkg::win_stat_t         stat
);

	logic [kvote_pkg::WINDOW_MAX-1:0] hist_q;
	logic [kvote_pkg::WIN_W-1:0]      fill_q;
	logic [kvote_pkg::WINDOW_MAX-1:0] hist_next;
	logic [kvote_pkg::WIN_W-1:0]      fill_next;
	logic [kvote_pkg::WINDOW_MAX-1:0] masked;
	logic [kvote_pkg::WIN_W-1:0]      group_sum [kvote_pkg::GROUPS];
	logic [kvote_pkg::WIN_W-1:0]      total;

	// Next history and saturating fill count for the transaction at hand.
	always_comb begin
		if (kvote_pkg::WINDOW_MAX > 1) begin
			hist_next = {hist_q[kvote_pkg::WINDOW_MAX-2:0], verdict};
		end else begin
			hist_next = kvote_pkg::WINDOW_MAX'(verdict);
		end
		if (fill_q < kvote_pkg::WIN_W'(kvote_pkg::WINDOW_MAX)) begin
			fill_next = fill_q + 1'b1;
		end else begin
			fill_next = fill_q;
		end
	end

	// Keep only the newest win verdicts, then count them in groups of eight.
	always_comb begin
		for (int i = 0; i < kvote_pkg::WINDOW_MAX; i++) begin
			masked[i] = hist_next[i] && (i < win);
		end
		for (int g = 0; g < kvote_pkg::GROUPS; g++) begin
			group_sum[g] = '0;
			for (int b = 0; b < kvote_pkg::GROUP_BITS; b++) begin
				if (g * kvote_pkg::GROUP_BITS + b < kvote_pkg::WINDOW_MAX) begin
					group_sum[g] = group_sum[g] +
						kvote_pkg::WIN_W'(masked[g * kvote_pkg::GROUP_BITS + b]);
				end
			end
		end
		total = '0;
		for (int g = 0; g < kvote_pkg::GROUPS; g++) begin
			total = total + group_sum[g];
		end
	end

	assign stat.count = total;
	assign stat.full  = (fill_next >= win);

	// State advances only when the transaction is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			fill_q <= '0;
		end else if (fire) begin
			hist_q <= hist_next;
			fill_q <= fill_next;
		end
	end

endmodule

`default_nettype wire

[rtl/core/kvote_alarm.sv]
// Episode latch, cooldown check and last alarm time.
`default_nettype none

module kvote_alarm (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              fire,
	input  wire                              wanted,
	input  wire                              player_ready,
	input  wire [kvote_pkg::TIME_BITS-1:0]   now,
	input  wire [kvote_pkg::COOL_W-1:0]      cooldown,
	output logic                             alarm
);

	logic                            latched_q;
	logic [kvote_pkg::TIME_BITS-1:0] last_time_q;
	logic [kvote_pkg::TIME_BITS-1:0] elapsed;
	logic                            cool_ok;
	logic                            trigger;

	// Elapsed time wraps at the timestamp width.
	always_comb begin
		elapsed = now - last_time_q;
		cool_ok = (kvote_pkg::CMP_W'(elapsed) >= kvote_pkg::CMP_W'(cooldown));
		trigger = wanted && !latched_q && cool_ok;
		alarm   = trigger && player_ready;
	end

	// A transaction that does not want an alarm ends the episode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q   <= 1'b0;
			last_time_q <= '0;
		end else if (fire) begin
			if (!wanted) begin
				latched_q <= 1'b0;
			end else if (trigger) begin
				latched_q <= 1'b1;
			end
			if (alarm) begin
				last_time_q <= now;
			end
		end
	end

endmodule

`default_nettype wire

[verif/tb_k_of_n_vote_alarm.sv]
// Self-checking testbench for the k-of-n sliding-window vote alarm.
`timescale 1ns / 1ps

module tb_k_of_n_vote_alarm;

	import kvote_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int DIRECTED_ROWS = 20;
	localparam int PHASES        = 13;
	localparam int FRAMES_PER_CFG = 31;
	localparam int LONG_STALL    = 64;
	localparam int STALL_PHASE   = 9;
	localparam int DRAIN_PAUSE   = 4;
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_CAP    = 50;

	// One directed frame, with a hand-worked result where one is obvious.
	typedef struct packed {
		logic                 fall;
		logic [TIME_BITS-1:0] ts;
		logic                 ready;
		logic                 typed;
		out_t                 want;
	} probe_row_t;

	// One setting of the three filter registers.
	typedef struct packed {
		logic [CFG_W-1:0]  win;
		logic [CFG_W-1:0]  votes;
		logic [COOL_W-1:0] cool;
	} filter_cfg_t;

	localparam out_t NO_WANT = '0;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_t                in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_t               out_data;
	logic               cfg_we    = 1'b0;
	cfg_idx_t           cfg_index = CFG_WINDOW_SIZE;
	logic [DATA_W-1:0]  cfg_data  = '0;

	// Filter state and register copies kept alongside the block.
	logic [WINDOW_MAX-1:0] verdict_bits     = '0;
	int                    frames_seen      = 0;
	logic                  episode_open     = 1'b0;
	logic [TIME_BITS-1:0]  last_alarm_tick  = '0;
	logic [CFG_W-1:0]      cfg_window       = WINDOW_SIZE_RST;
	logic [CFG_W-1:0]      cfg_votes_needed = REQUIRED_VOTES_RST;
	logic [COOL_W-1:0]     cfg_cooldown     = COOLDOWN_RST;

	// Stimulus shaping state.
	logic [TIME_BITS-1:0] stamp      = '0;
	int                   burst_left = 0;
	logic                 burst_hot  = 1'b0;

	out_t due_reports[$];
	int   mismatches     = 0;
	int   idle_cycles    = 0;
	int   send_idle_pct  = 0;
	int   recv_idle_pct  = 0;
	logic long_stall_req = 1'b0;
	int   stall_left     = 0;

	// The directed frames run under the reset settings: eight-deep window, six votes,
	// 3000-tick cooldown. They cover the cooldown holding back the first alarm, a
	// player that is not ready, the latch clearing and re-arming, and timestamp wrap.
	probe_row_t probe_rows [DIRECTED_ROWS] = '{
		'{1'b1, 32'd0,          1'b1, 1'b1, '{1'b0, 6'd1, 1'b0, 1'b0}},
		'{1'b1, 32'd10,         1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd20,         1'b0, 1'b0, NO_WANT},
		'{1'b1, 32'd30,         1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd40,         1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd50,         1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd60,         1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd100,        1'b1, 1'b1, '{1'b0, 6'd8, 1'b1, 1'b0}},
		'{1'b1, 32'd3000,       1'b0, 1'b1, '{1'b0, 6'd8, 1'b1, 1'b0}},
		'{1'b0, 32'd3001,       1'b1, 1'b0, NO_WANT},
		'{1'b0, 32'd3002,       1'b1, 1'b0, NO_WANT},
		'{1'b0, 32'd3003,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd3500,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd3600,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd3700,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd3800,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd3900,       1'b1, 1'b0, NO_WANT},
		'{1'b1, 32'd4000,       1'b1, 1'b1, '{1'b1, 6'd6, 1'b1, 1'b0}},
		'{1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, NO_WANT},
		'{1'b0, 32'd0,          1'b1, 1'b0, NO_WANT}
	};

	// Register settings for the random phases: both extremes of each register, every
	// kind of invalid setting, and a few ordinary ones. The history is never cleared,
	// so each change of window happens mid-stream.
	filter_cfg_t phase_cfg [PHASES] = '{
		'{6'd1,  6'd1,  32'd0},
		'{6'd32, 6'd32, 32'd0},
		'{6'd32, 6'd1,  32'hFFFF_FFFF},
		'{6'd0,  6'd0,  32'd5},
		'{6'd5,  6'd6,  32'd0},
		'{6'd40, 6'd10, 32'd100},
		'{6'd63, 6'd63, 32'h8000_0000},
		'{6'd16, 6'd12, 32'd50},
		'{6'd4,  6'd3,  32'd20},
		'{6'd8,  6'd6,  32'd3000},
		'{6'd24, 6'd20, 32'd1},
		'{6'd12, 6'd1,  32'd200},
		'{6'd8,  6'd0,  32'd10}
	};

	k_of_n_vote_alarm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Works out the result of one verdict and advances the filter state.
	function automatic out_t vote_filter_step(input in_t frame);
		logic [WINDOW_MAX-1:0] in_window;
		logic [TIME_BITS-1:0]  elapsed;
		int                    span;
		int                    ones;
		logic                  full;
		logic                  bad_cfg;
		logic                  wanted;
		out_t                  res;
		span    = (cfg_window > WINDOW_MAX) ? WINDOW_MAX : int'(cfg_window);
		bad_cfg = (cfg_votes_needed == 0) || (cfg_votes_needed > cfg_window) ||
			(cfg_window > WINDOW_MAX);
		verdict_bits = {verdict_bits[WINDOW_MAX-2:0], frame.fall_seen};
		if (frames_seen < WINDOW_MAX) begin
			frames_seen++;
		end
		// An oversized window counts over the whole history only.
		in_window = verdict_bits & ({WINDOW_MAX{1'b1}} >> (WINDOW_MAX - span));
		ones = 0;
		for (int b = 0; b < WINDOW_MAX; b++) begin
			ones += in_window[b];
		end
		full    = frames_seen >= span;
		wanted  = !bad_cfg && full && (ones >= cfg_votes_needed);
		elapsed = frame.timestamp - last_alarm_tick;
		res     = '0;
		// One alarm per episode; a player that is not ready still latches the episode.
		if (!wanted) begin
			episode_open = 1'b0;
		end else if (!episode_open && elapsed >= cfg_cooldown) begin
			episode_open = 1'b1;
			if (frame.player_ready) begin
				last_alarm_tick = frame.timestamp;
				res.alarm       = 1'b1;
			end
		end
		res.votes        = ones[VOTES_W-1:0];
		res.window_full  = full;
		res.config_error = bad_cfg;
		return res;
	endfunction

	// Random verdicts come in hot and quiet bursts so that full windows reach the
	// threshold; timestamps often land on or just short of the cooldown boundary.
	function automatic in_t draw_frame();
		in_t f;
		int  pick;
		if (burst_left == 0) begin
			burst_hot  = ($urandom_range(99) < 55);
			burst_left = $urandom_range(40, 3);
		end
		burst_left--;
		pick = $urandom_range(99);
		if (pick < 8) begin
			f.fall_seen = $urandom_range(1);
		end else if (burst_hot) begin
			f.fall_seen = (pick < 93);
		end else begin
			f.fall_seen = (pick >= 90);
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			stamp = last_alarm_tick + cfg_cooldown;
		end else if (pick < 15) begin
			stamp = last_alarm_tick + cfg_cooldown - 1;
		end else if (pick >= 25 && pick < 30) begin
			stamp = stamp + $urandom;
		end else if (pick >= 30 && pick < 70) begin
			stamp = stamp + $urandom_range(64, 1);
		end else if (pick >= 70) begin
			stamp = stamp + $urandom_range((cfg_cooldown > 4000) ? 4000 : cfg_cooldown, 0);
		end
		f.timestamp    = stamp;
		f.player_ready = ($urandom_range(99) < 75);
		return f;
	endfunction

	// Offers one transaction and queues its expected result once it is taken.
	task automatic offer(input in_t frame, input logic typed, input out_t want);
		out_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= frame;
		@(negedge clk);
		while (!in_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		guess = vote_filter_step(frame);
		due_reports.insert(due_reports.size(), typed ? want : guess);
	endtask

	// Stops offering and lets every outstanding result come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// Writes all three registers; the narrow ones get random upper bits.
	task automatic program_filter(input filter_cfg_t s);
		logic [DATA_W-1:0] junk;
		junk      = $urandom;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WINDOW_SIZE;
		cfg_data  <= {junk[DATA_W-1:CFG_W], s.win};
		cfg_window = s.win;
		@(posedge clk);
		junk      = $urandom;
		cfg_index <= CFG_REQUIRED_VOTES;
		cfg_data  <= {junk[DATA_W-1:CFG_W], s.votes};
		cfg_votes_needed = s.votes;
		@(posedge clk);
		cfg_index <= CFG_COOLDOWN_TICKS;
		cfg_data  <= s.cool;
		cfg_cooldown = s.cool;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_CAP) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (long_stall_req) begin
			long_stall_req = 1'b0;
			stall_left     = LONG_STALL - 1;
			out_ready      <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checking and watchdog, sampled mid-cycle where every signal is settled.
	always @(negedge clk) begin
		out_t due;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					mismatches++;
					$display("%0t: result transaction with none expected, actual %p",
						$time, out_data);
				end else begin
					due = due_reports[0];
					due_reports.delete(0);
					check_field("alarm", due.alarm, out_data.alarm);
					check_field("votes", due.votes, out_data.votes);
					check_field("window_full", due.window_full, out_data.window_full);
					check_field("config_error", due.config_error, out_data.config_error);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed frames, then one random phase per setting.
	initial begin
		in_t frame;
		send_idle_pct = 11;
		recv_idle_pct = 77;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			frame.fall_seen    = probe_rows[i].fall;
			frame.timestamp    = probe_rows[i].ts;
			frame.player_ready = probe_rows[i].ready;
			offer(frame, probe_rows[i].typed, probe_rows[i].want);
		end
		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_filter(phase_cfg[p]);
			// Sender-light then receiver-light idling, then none at all.
			send_idle_pct = (p < 4) ? 11 : ((p < STALL_PHASE) ? 77 : 0);
			recv_idle_pct = (p < 4) ? 77 : ((p < STALL_PHASE) ? 11 : 0);
			if (p == STALL_PHASE) begin
				long_stall_req = 1'b1;
			end
			for (int n = 0; n < FRAMES_PER_CFG; n++) begin
				offer(draw_frame(), 1'b0, NO_WANT);
			end
		end
		settle();
		if (mismatches == 0 && due_reports.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
